// ===== rtl/core/fcr_pkg.sv =====
// Shared types and constants of the framed command receiver.
package fcr_pkg;

	localparam logic [7:0] ACK_BYTE     = 8'h55;
	localparam logic [7:0] NAK_BYTE     = 8'hAA;
	localparam logic [7:0] TIMEOUT_BYTE = 8'h30;

	localparam logic [15:0] TIMEOUT_RESET = 16'd3040;
	localparam logic [7:0]  START_RESET   = 8'h1A;
	localparam logic [7:0]  STOP_RESET    = 8'hB3;

	localparam logic [1:0] CFG_TIMEOUT = 2'd0;
	localparam logic [1:0] CFG_START   = 2'd1;
	localparam logic [1:0] CFG_STOP    = 2'd2;

	// Result index of the final echoed byte (ACK first, then eight bytes).
	localparam logic [3:0] ECHO_LAST = 4'd8;

	typedef struct packed {
		logic       cmd;
		logic [7:0] rx_byte;
	} in_item_t;

	typedef struct packed {
		logic        tx_valid;
		logic [7:0]  tx_byte;
		logic        update_valid;
		logic [3:0]  setting_id;
		logic [15:0] setting_value;
		logic        last;
	} out_item_t;

	// One queued reply: either a single result or ACK followed by the frame echo.
	typedef struct packed {
		logic            echo;
		logic [7:0]      tx_byte;
		logic            update_valid;
		logic [3:0]      setting_id;
		logic [15:0]     setting_value;
		logic [7:0][7:0] frame;
	} job_t;

	typedef struct packed {
		logic not_empty;
		logic full;
	} queue_status_t;

endpackage

// ===== rtl/core/fcr_front.sv =====
// Front end: frame assembly, command store, timeout timer and reply classification.
module fcr_front import fcr_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  in_item_t      in_data,
	input  logic          cfg_valid,
	input  logic [1:0]    cfg_index,
	input  logic [15:0]   cfg_data,
	input  queue_status_t qstat,
	output logic          in_stall,
	output logic          push,
	output job_t          job
);

	logic [15:0]     timeout_limit_q;
	logic [7:0]      start_marker_q;
	logic [7:0]      stop_marker_q;
	logic [7:0][7:0] frame_q, frame_n;
	logic [2:0]      count_q, count_n;
	logic [7:0]      stored_cmd_q, stored_cmd_n;
	logic [7:0]      data2_q, data2_n;
	logic [7:0]      data3_q, data3_n;
	logic [15:0]     timer_q, timer_n;
	logic            armed_q, armed_n;
	logic [7:0]      sum;
	logic            accept;

	assign in_stall = qstat.full;
	assign accept = in_valid && !in_stall;
	assign sum = frame_q[2] + frame_q[3] + frame_q[4] + frame_q[5] + frame_q[6];

	always_comb begin
		frame_n      = frame_q;
		count_n      = count_q;
		stored_cmd_n = stored_cmd_q;
		data2_n      = data2_q;
		data3_n      = data3_q;
		timer_n      = timer_q;
		armed_n      = armed_q;
		push         = 1'b0;
		job          = '0;
		job.frame    = frame_q;
		if (accept) begin
			if (!in_data.cmd) begin
				frame_n[count_q] = in_data.rx_byte;
				job.frame = frame_n;
				if (count_q == 3'd7) begin
					count_n = 3'd0;
					if (frame_q[0] == start_marker_q && in_data.rx_byte == stop_marker_q) begin
						if (frame_q[1] == ACK_BYTE) begin
							push = 1'b1;
							job.tx_byte = ACK_BYTE;
							case (stored_cmd_q) inside
								8'd1, 8'd4, 8'd5: begin
									job.update_valid  = 1'b1;
									job.setting_id    = stored_cmd_q[3:0];
									job.setting_value = {8'd0, data3_q};
								end
								8'd13: begin
									job.update_valid = 1'b1;
									job.setting_id   = stored_cmd_q[3:0];
								end
								[8'd2:8'd12]: begin
									job.update_valid  = 1'b1;
									job.setting_id    = stored_cmd_q[3:0];
									job.setting_value = {data2_q, data3_q};
								end
								default: begin
									job.update_valid = 1'b0;
								end
							endcase
						end else if (frame_q[1] == NAK_BYTE) begin
							stored_cmd_n = 8'd0;
							data2_n      = 8'd0;
							data3_n      = 8'd0;
						end else if (sum == 8'd0) begin
							push         = 1'b1;
							job.echo     = 1'b1;
							job.tx_byte  = ACK_BYTE;
							stored_cmd_n = frame_q[1];
							data2_n      = frame_q[4];
							data3_n      = frame_q[5];
						end else begin
							push         = 1'b1;
							job.tx_byte  = NAK_BYTE;
							stored_cmd_n = 8'd0;
							data2_n      = 8'd0;
							data3_n      = 8'd0;
						end
					end
				end else begin
					count_n = count_q + 3'd1;
				end
				// The first byte of a partial frame arms the timer.
				if (count_n != 3'd0 && !armed_q) begin
					timer_n = 16'd0;
					armed_n = 1'b1;
				end
			end else begin
				if (timer_q != 16'hFFFF) begin
					timer_n = timer_q + 16'd1;
				end
				if (armed_q && timer_n > timeout_limit_q) begin
					push         = 1'b1;
					job.tx_byte  = TIMEOUT_BYTE;
					armed_n      = 1'b0;
					count_n      = 3'd0;
					stored_cmd_n = 8'd0;
					data2_n      = 8'd0;
					data3_n      = 8'd0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_limit_q <= TIMEOUT_RESET;
			start_marker_q  <= START_RESET;
			stop_marker_q   <= STOP_RESET;
			count_q         <= 3'd0;
			stored_cmd_q    <= 8'd0;
			data2_q         <= 8'd0;
			data3_q         <= 8'd0;
			timer_q         <= 16'd0;
			armed_q         <= 1'b0;
		end else begin
			count_q      <= count_n;
			stored_cmd_q <= stored_cmd_n;
			data2_q      <= data2_n;
			data3_q      <= data3_n;
			timer_q      <= timer_n;
			armed_q      <= armed_n;
			if (cfg_valid) begin
				case (cfg_index)
					CFG_TIMEOUT: timeout_limit_q <= cfg_data;
					CFG_START:   start_marker_q  <= cfg_data[7:0];
					CFG_STOP:    stop_marker_q   <= cfg_data[7:0];
					default: begin
					end
				endcase
			end
		end
	end

	// Frame bytes are always written before they are read, so they need no reset.
	always_ff @(posedge clk) begin
		frame_q <= frame_n;
	end

endmodule

// ===== rtl/core/fcr_queue.sv =====
// Two-entry reply queue between the front end and the result sequencer.
module fcr_queue import fcr_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  job_t          push_job,
	input  logic          pop,
	output job_t          head,
	output queue_status_t qstat
);

	job_t       entry_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] fill_q;

	assign head            = entry_q[rd_ptr_q];
	assign qstat.not_empty = fill_q != 2'd0;
	assign qstat.full      = fill_q == 2'd2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   fill_q <= fill_q + 2'd1;
				2'b01:   fill_q <= fill_q - 2'd1;
				default: fill_q <= fill_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_job;
		end
	end

endmodule

// ===== rtl/core/fcr_back.sv =====
// Back end: expands each queued reply into result items through an output register.
module fcr_back import fcr_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  job_t          head,
	input  queue_status_t qstat,
	input  logic          out_stall,
	output logic          pop,
	output logic          out_valid,
	output out_item_t     out_data
);

	logic [3:0] idx_q;
	logic [3:0] idx_m1;
	logic       out_valid_q;
	out_item_t  out_q;
	out_item_t  item;
	logic       load;

	assign idx_m1 = idx_q - 4'd1;
	assign load   = qstat.not_empty && (!out_valid_q || !out_stall);

	always_comb begin
		item               = '0;
		item.tx_valid      = 1'b1;
		item.tx_byte       = head.tx_byte;
		item.update_valid  = head.update_valid;
		item.setting_id    = head.setting_id;
		item.setting_value = head.setting_value;
		item.last          = 1'b1;
		if (head.echo) begin
			item.last = idx_q == ECHO_LAST;
			if (idx_q != 4'd0) begin
				item.tx_byte = head.frame[idx_m1[2:0]];
			end
		end
	end

	assign pop       = load && item.last;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= 4'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				idx_q       <= item.last ? 4'd0 : idx_q + 4'd1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_q <= item;
		end
	end

endmodule

// ===== rtl/core/framed_command_receiver.sv =====
// Top level of the framed command receiver: front end, reply queue and result sequencer.
//
//   channel  direction  handshake            payload
//   in       input      in_valid / in_stall  in_item_t  (cmd, rx_byte)
//   out      output     out_valid/out_stall  out_item_t (tx byte and setting update)
//   cfg      input      cfg_valid/cfg_ready  cfg_index, cfg_data
//
// The front end takes one request per cycle while the two-entry reply queue has room.
// The result sequencer sends one result per cycle while the output is not stalled: a single reply gives one result,
// an accepted frame gives nine (ACK plus the eight echoed bytes).
// The output register is reloaded in the same cycle its result is taken.
// Reset clears all control state and loads the register reset values.
module framed_command_receiver import fcr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  in_item_t    in_data,
	output logic        out_valid,
	input  logic        out_stall,
	output out_item_t   out_data,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	queue_status_t qstat;
	logic          push;
	logic          pop;
	job_t          push_job;
	job_t          head;

	assign cfg_ready = 1'b1;

	fcr_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_data   (in_data),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.qstat     (qstat),
		.in_stall  (in_stall),
		.push      (push),
		.job       (push_job)
	);

	fcr_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.head     (head),
		.qstat    (qstat)
	);

	fcr_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.qstat     (qstat),
		.out_stall (out_stall),
		.pop       (pop),
		.out_valid (out_valid),
		.out_data  (out_data)
	);

endmodule
